// ===== hw/rtl/bpfm_pkg.sv =====
// package: sizes, codes and transfer types of the buffer pool frame manager
`timescale 1ns / 1ps
package bpfm_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int PIN_BITS   = 16;
  localparam int PAGE_W     = 32;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

  localparam logic [2:0] REQ_FETCH  = 3'd0;
  localparam logic [2:0] REQ_NEW    = 3'd1;
  localparam logic [2:0] REQ_UNPIN  = 3'd2;
  localparam logic [2:0] REQ_FLUSH  = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_IN_POOL  = 3'd1;
  localparam logic [2:0] ST_NO_FREE      = 3'd2;
  localparam logic [2:0] ST_STILL_PINNED = 3'd3;
  localparam logic [2:0] ST_NOT_PINNED   = 3'd4;
  localparam logic [2:0] ST_PIN_SAT      = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HIT_RD,
    S_HIT_EVAL,
    S_VIC_RD,
    S_VIC_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [PAGE_W-1:0] page_num;
    logic              mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              hit;
    logic [5:0]        frame_index;
    logic              read_request;
    logic              writeback_request;
    logic [PAGE_W-1:0] writeback_page;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [PIN_BITS-1:0] pins;
  } meta_t;

endpackage

// ===== hw/rtl/bpfm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
module bpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/buffer_pool_frame_manager_lru.sv =====
// top level: buffer pool frame manager with lru replacement
`timescale 1ns / 1ps
// One request at a time, one result per request. A request first scans the
// frame table one frame per cycle through the page and metadata memories and
// stops at the lowest frame that holds the page. A hit then reads and
// evaluates that frame's metadata, a miss that takes a frame reads and
// evaluates the victim; the result register is loaded once the output is free,
// and the block returns to idle before the next request is taken. The lru order
// is a doubly linked list kept in two small memories, the free list a circular
// queue in a third. After reset a clearing pass over every frame resets the
// frame metadata and fills the free list; requests are stalled until it ends.
// A new request is taken while the last result still waits on a stalled output.
module buffer_pool_frame_manager_lru (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bpfm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bpfm_pkg::rsp_t rsp
);

  localparam int IDX_W  = bpfm_pkg::IDX_W;
  localparam int CNT_W  = bpfm_pkg::CNT_W;
  localparam int META_W = $bits(bpfm_pkg::meta_t);
  localparam logic [bpfm_pkg::PIN_BITS-1:0] PIN_MAX = '1;

  bpfm_pkg::state_t state, state_next;
  bpfm_pkg::req_t   req_q, req_q_next;
  bpfm_pkg::rsp_t   res, res_next;
  bpfm_pkg::rsp_t   rsp_next;
  logic             rsp_valid_next;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] found_idx, found_idx_next;
  logic [IDX_W-1:0] victim, victim_next;
  logic             from_lru, from_lru_next;
  logic [IDX_W-1:0] free_head, free_head_next;
  logic [CNT_W-1:0] free_count, free_count_next;
  logic [IDX_W-1:0] lru_head, lru_head_next;
  logic [IDX_W-1:0] lru_tail, lru_tail_next;
  logic [CNT_W-1:0] lru_count, lru_count_next;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] scan_prev;
  logic             match;
  logic             is_alloc;
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] free_tail;

  logic                       page_we;
  logic [IDX_W-1:0]           page_waddr;
  logic [bpfm_pkg::PAGE_W-1:0] page_wdata, page_rdata;
  logic                       meta_we;
  logic [IDX_W-1:0]           meta_waddr;
  bpfm_pkg::meta_t            meta_wd, meta_rd;
  logic [META_W-1:0]          meta_rvec;
  logic                       prev_we, next_we;
  logic [IDX_W-1:0]           prev_waddr, prev_wdata, prev_rdata;
  logic [IDX_W-1:0]           next_waddr, next_wdata, next_rdata;
  logic                       free_we;
  logic [IDX_W-1:0]           free_waddr, free_wdata, free_rdata;

  logic             do_remove, do_push;
  logic [IDX_W-1:0] lf;

  assign meta_rd   = bpfm_pkg::meta_t'(meta_rvec);
  assign scan_prev = IDX_W'(cnt - CNT_W'(1));
  assign match     = (state == bpfm_pkg::S_SCAN) && (cnt != '0) && meta_rd.valid
                     && (page_rdata == req_q.page_num);
  assign is_alloc  = (req_q.req_type == bpfm_pkg::REQ_FETCH)
                     || (req_q.req_type == bpfm_pkg::REQ_NEW);
  assign tail_sum  = (CNT_W+1)'(free_head) + (CNT_W+1)'(free_count);
  assign free_tail = (tail_sum >= (CNT_W+1)'(bpfm_pkg::NUM_FRAMES))
                     ? IDX_W'(tail_sum - (CNT_W+1)'(bpfm_pkg::NUM_FRAMES))
                     : IDX_W'(tail_sum);
  assign req_stall = (state != bpfm_pkg::S_IDLE);

  bpfm_ram #(.WIDTH(bpfm_pkg::PAGE_W), .DEPTH(bpfm_pkg::NUM_FRAMES)) u_page_ram (
    .clk(clk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
    .raddr(rd_addr), .rdata(page_rdata)
  );

  bpfm_ram #(.WIDTH(META_W), .DEPTH(bpfm_pkg::NUM_FRAMES)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wd),
    .raddr(rd_addr), .rdata(meta_rvec)
  );

  bpfm_ram #(.WIDTH(IDX_W), .DEPTH(bpfm_pkg::NUM_FRAMES)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(rd_addr), .rdata(prev_rdata)
  );

  bpfm_ram #(.WIDTH(IDX_W), .DEPTH(bpfm_pkg::NUM_FRAMES)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(rd_addr), .rdata(next_rdata)
  );

  bpfm_ram #(.WIDTH(IDX_W), .DEPTH(bpfm_pkg::NUM_FRAMES)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_head), .rdata(free_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bpfm_pkg::S_CLEAR: begin
        if (cnt == CNT_W'(bpfm_pkg::NUM_FRAMES - 1)) begin
          state_next = bpfm_pkg::S_IDLE;
        end
      end
      bpfm_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = bpfm_pkg::S_SCAN;
        end
      end
      bpfm_pkg::S_SCAN: begin
        if (req_q.req_type > bpfm_pkg::REQ_DELETE) begin
          state_next = bpfm_pkg::S_DONE;
        end else if (match) begin
          state_next = bpfm_pkg::S_HIT_RD;
        end else if (cnt == CNT_W'(bpfm_pkg::NUM_FRAMES)) begin
          if (is_alloc && ((free_count != '0) || (lru_count != '0))) begin
            state_next = bpfm_pkg::S_VIC_RD;
          end else begin
            state_next = bpfm_pkg::S_DONE;
          end
        end
      end
      bpfm_pkg::S_HIT_RD:   state_next = bpfm_pkg::S_HIT_EVAL;
      bpfm_pkg::S_HIT_EVAL: state_next = bpfm_pkg::S_DONE;
      bpfm_pkg::S_VIC_RD:   state_next = bpfm_pkg::S_VIC_EVAL;
      bpfm_pkg::S_VIC_EVAL: state_next = bpfm_pkg::S_DONE;
      bpfm_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = bpfm_pkg::S_IDLE;
        end
      end
      default: state_next = bpfm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_q_next      = req_q;
    res_next        = res;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && rsp_stall;
    cnt_next        = cnt;
    found_idx_next  = found_idx;
    victim_next     = victim;
    from_lru_next   = from_lru;
    free_head_next  = free_head;
    free_count_next = free_count;
    lru_head_next   = lru_head;
    lru_tail_next   = lru_tail;
    lru_count_next  = lru_count;
    rd_addr         = found_idx;
    page_we         = 1'b0;
    page_waddr      = victim;
    page_wdata      = req_q.page_num;
    meta_we         = 1'b0;
    meta_waddr      = found_idx;
    meta_wd         = meta_rd;
    prev_we         = 1'b0;
    prev_waddr      = '0;
    prev_wdata      = '0;
    next_we         = 1'b0;
    next_waddr      = '0;
    next_wdata      = '0;
    free_we         = 1'b0;
    free_waddr      = free_tail;
    free_wdata      = found_idx;
    do_remove       = 1'b0;
    do_push         = 1'b0;
    lf              = found_idx;

    case (state)
      bpfm_pkg::S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = IDX_W'(cnt);
        meta_wd    = '0;
        free_we    = 1'b1;
        free_waddr = IDX_W'(cnt);
        free_wdata = IDX_W'(cnt);
        cnt_next   = cnt + CNT_W'(1);
      end
      bpfm_pkg::S_IDLE: begin
        if (req_valid) begin
          req_q_next = req;
          res_next   = '0;
          cnt_next   = '0;
        end
      end
      bpfm_pkg::S_SCAN: begin
        rd_addr  = IDX_W'(cnt);
        cnt_next = cnt + CNT_W'(1);
        if (match) begin
          found_idx_next       = scan_prev;
          res_next.hit         = 1'b1;
          res_next.frame_index = 6'(scan_prev);
        end else if (cnt == CNT_W'(bpfm_pkg::NUM_FRAMES)) begin
          if (is_alloc) begin
            if (free_count != '0) begin
              victim_next     = free_rdata;
              from_lru_next   = 1'b0;
              free_head_next  = (free_head == IDX_W'(bpfm_pkg::NUM_FRAMES - 1))
                                ? '0 : free_head + IDX_W'(1);
              free_count_next = free_count - CNT_W'(1);
            end else if (lru_count != '0) begin
              victim_next   = lru_head;
              from_lru_next = 1'b1;
            end else begin
              res_next.status = bpfm_pkg::ST_NO_FREE;
            end
          end else if (req_q.req_type != bpfm_pkg::REQ_DELETE) begin
            res_next.status = bpfm_pkg::ST_NOT_IN_POOL;
          end
        end
      end
      bpfm_pkg::S_HIT_RD: begin
        rd_addr = found_idx;
      end
      bpfm_pkg::S_HIT_EVAL: begin
        meta_waddr = found_idx;
        case (req_q.req_type)
          bpfm_pkg::REQ_FETCH, bpfm_pkg::REQ_NEW: begin
            if (meta_rd.pins == PIN_MAX) begin
              res_next.status = bpfm_pkg::ST_PIN_SAT;
            end else begin
              meta_we      = 1'b1;
              meta_wd.pins = meta_rd.pins + bpfm_pkg::PIN_BITS'(1);
              if (req_q.req_type == bpfm_pkg::REQ_NEW) begin
                meta_wd.dirty = 1'b1;
              end
              do_remove = (meta_rd.pins == '0);
            end
          end
          bpfm_pkg::REQ_UNPIN: begin
            if (meta_rd.pins == '0) begin
              res_next.status = bpfm_pkg::ST_NOT_PINNED;
            end else begin
              meta_we       = 1'b1;
              meta_wd.pins  = meta_rd.pins - bpfm_pkg::PIN_BITS'(1);
              meta_wd.dirty = meta_rd.dirty | req_q.mark_dirty;
              do_push       = (meta_rd.pins == bpfm_pkg::PIN_BITS'(1));
            end
          end
          bpfm_pkg::REQ_FLUSH: begin
            if (meta_rd.dirty) begin
              res_next.writeback_request = 1'b1;
              res_next.writeback_page    = req_q.page_num;
              meta_we                    = 1'b1;
              meta_wd.dirty              = 1'b0;
            end
          end
          bpfm_pkg::REQ_DELETE: begin
            if (meta_rd.pins != '0) begin
              res_next.status = bpfm_pkg::ST_STILL_PINNED;
            end else begin
              do_remove = 1'b1;
              meta_we   = 1'b1;
              meta_wd   = '0;
              if (free_count != CNT_W'(bpfm_pkg::NUM_FRAMES)) begin
                free_we         = 1'b1;
                free_wdata      = found_idx;
                free_count_next = free_count + CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
      bpfm_pkg::S_VIC_RD: begin
        rd_addr = victim;
      end
      bpfm_pkg::S_VIC_EVAL: begin
        lf         = victim;
        meta_waddr = victim;
        if (meta_rd.valid && meta_rd.dirty) begin
          res_next.writeback_request = 1'b1;
          res_next.writeback_page    = page_rdata;
        end
        page_we               = 1'b1;
        meta_we               = 1'b1;
        meta_wd.valid         = 1'b1;
        meta_wd.dirty         = (req_q.req_type == bpfm_pkg::REQ_NEW);
        meta_wd.pins          = bpfm_pkg::PIN_BITS'(1);
        res_next.frame_index  = 6'(victim);
        res_next.read_request = (req_q.req_type == bpfm_pkg::REQ_FETCH);
        do_remove             = from_lru;
      end
      bpfm_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
        end
      end
      default: ;
    endcase

    // lru list unlink
    if (do_remove) begin
      if (lf == lru_head) begin
        lru_head_next = next_rdata;
      end else begin
        next_we    = 1'b1;
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
      end
      if (lf == lru_tail) begin
        lru_tail_next = prev_rdata;
      end else begin
        prev_we    = 1'b1;
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
      end
      lru_count_next = lru_count - CNT_W'(1);
    end

    // lru list append at most recent end
    if (do_push) begin
      if (lru_count == '0) begin
        lru_head_next = lf;
      end else begin
        next_we    = 1'b1;
        next_waddr = lru_tail;
        next_wdata = lf;
        prev_we    = 1'b1;
        prev_waddr = lf;
        prev_wdata = lru_tail;
      end
      lru_tail_next  = lf;
      lru_count_next = lru_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpfm_pkg::S_CLEAR;
      cnt        <= '0;
      free_head  <= '0;
      free_count <= CNT_W'(bpfm_pkg::NUM_FRAMES);
      lru_count  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      free_head  <= free_head_next;
      free_count <= free_count_next;
      lru_count  <= lru_count_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q     <= req_q_next;
    res       <= res_next;
    rsp       <= rsp_next;
    found_idx <= found_idx_next;
    victim    <= victim_next;
    from_lru  <= from_lru_next;
    lru_head  <= lru_head_next;
    lru_tail  <= lru_tail_next;
  end

`ifndef SYNTH
  a_frame_budget: assert property (@(posedge clk) disable iff (rst)
    (32'(lru_count) + 32'(free_count)) <= 32'(bpfm_pkg::NUM_FRAMES))
    else $error("free and lru lists hold more frames than exist");

  a_read_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.read_request) |-> (rsp.status == bpfm_pkg::ST_OK && !rsp.hit))
    else $error("read request on a hit or failed request");

  a_wb_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.writeback_request) |-> (rsp.status == bpfm_pkg::ST_OK))
    else $error("write-back requested with an error status");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (state == bpfm_pkg::S_DONE && !(rsp_valid && rsp_stall)) |=> rsp_valid)
    else $error("finished result not presented");
`endif

endmodule

// ===== test/tb_top.sv =====
// testbench: request stream, page table predictor and result checking for the frame manager
`timescale 1ns / 1ps
module tb_top;

  localparam int PIN_MAX = (1 << bpfm_pkg::PIN_BITS) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bpfm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bpfm_pkg::rsp_t rsp;

  always #5 clk = ~clk;

  buffer_pool_frame_manager_lru dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  logic [bpfm_pkg::PAGE_W-1:0] pg_num [bpfm_pkg::NUM_FRAMES];
  logic                        pg_valid [bpfm_pkg::NUM_FRAMES];
  logic                        pg_dirty [bpfm_pkg::NUM_FRAMES];
  int                          pg_pins [bpfm_pkg::NUM_FRAMES];
  int                          free_q [$];
  int                          lru_q [$];
  bpfm_pkg::rsp_t              pending [$];

  int errors = 0;
  int checked = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  logic [bpfm_pkg::PAGE_W-1:0] hot [8];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic int find_page(input logic [bpfm_pkg::PAGE_W-1:0] p);
    for (int i = 0; i < bpfm_pkg::NUM_FRAMES; i++)
      if (pg_valid[i] && pg_num[i] == p) return i;
    return -1;
  endfunction

  function automatic void lru_drop(input int f);
    for (int i = 0; i < lru_q.size(); i++)
      if (lru_q[i] == f) begin
        lru_q.delete(i);
        return;
      end
  endfunction

  function automatic bpfm_pkg::rsp_t predict_frame_op(input bpfm_pkg::req_t r);
    bpfm_pkg::rsp_t o;
    int f;
    int v;
    o = '0;
    f = (r.req_type <= bpfm_pkg::REQ_DELETE) ? find_page(r.page_num) : -1;
    case (r.req_type)
      bpfm_pkg::REQ_FETCH, bpfm_pkg::REQ_NEW: begin
        if (f >= 0) begin
          o.hit = 1'b1;
          o.frame_index = f[5:0];
          if (pg_pins[f] >= PIN_MAX) o.status = bpfm_pkg::ST_PIN_SAT;
          else begin
            pg_pins[f]++;
            lru_drop(f);
            if (r.req_type == bpfm_pkg::REQ_NEW) pg_dirty[f] = 1'b1;
          end
        end else begin
          v = -1;
          if (free_q.size() > 0) begin
            v = free_q[0];
            free_q.delete(0);
          end else if (lru_q.size() > 0) begin
            v = lru_q[0];
            lru_q.delete(0);
          end
          if (v < 0) o.status = bpfm_pkg::ST_NO_FREE;
          else begin
            o.frame_index = v[5:0];
            if (pg_valid[v] && pg_dirty[v]) begin
              o.writeback_request = 1'b1;
              o.writeback_page = pg_num[v];
            end
            pg_num[v] = r.page_num;
            pg_valid[v] = 1'b1;
            pg_pins[v] = 1;
            pg_dirty[v] = (r.req_type == bpfm_pkg::REQ_NEW);
            o.read_request = (r.req_type == bpfm_pkg::REQ_FETCH);
          end
        end
      end
      bpfm_pkg::REQ_UNPIN: begin
        if (f < 0) o.status = bpfm_pkg::ST_NOT_IN_POOL;
        else begin
          o.hit = 1'b1;
          o.frame_index = f[5:0];
          if (pg_pins[f] == 0) o.status = bpfm_pkg::ST_NOT_PINNED;
          else begin
            pg_pins[f]--;
            if (r.mark_dirty) pg_dirty[f] = 1'b1;
            if (pg_pins[f] == 0) lru_q = {lru_q, f};
          end
        end
      end
      bpfm_pkg::REQ_FLUSH: begin
        if (f < 0) o.status = bpfm_pkg::ST_NOT_IN_POOL;
        else begin
          o.hit = 1'b1;
          o.frame_index = f[5:0];
          if (pg_dirty[f]) begin
            o.writeback_request = 1'b1;
            o.writeback_page = pg_num[f];
            pg_dirty[f] = 1'b0;
          end
        end
      end
      bpfm_pkg::REQ_DELETE: begin
        if (f >= 0) begin
          o.hit = 1'b1;
          o.frame_index = f[5:0];
          if (pg_pins[f] > 0) o.status = bpfm_pkg::ST_STILL_PINNED;
          else begin
            lru_drop(f);
            pg_valid[f] = 1'b0;
            pg_dirty[f] = 1'b0;
            pg_pins[f] = 0;
            free_q = {free_q, f};
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_req(input logic [2:0] t, input logic [bpfm_pkg::PAGE_W-1:0] p,
                          input logic md);
    bpfm_pkg::req_t r;
    bpfm_pkg::rsp_t o;
    r.req_type = t;
    r.page_num = p;
    r.mark_dirty = md;
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    o = predict_frame_op(r);
    pending = {pending, o};
  endtask

  task automatic drain;
    int n;
    n = 0;
    req_valid <= 1'b0;
    while (pending.size() > 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (300) @(posedge clk);
  endtask

  // receiver side: stall pattern and hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall <= 1'b1;
    end else rsp_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    bpfm_pkg::rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending.size() == 0) report("unexpected result", rsp, 0);
      else begin
        e = pending[0];
        pending.delete(0);
        if (rsp.status != e.status) report("status", rsp.status, e.status);
        if (rsp.hit != e.hit) report("hit", rsp.hit, e.hit);
        if (rsp.frame_index != e.frame_index) report("frame_index", rsp.frame_index, e.frame_index);
        if (rsp.read_request != e.read_request) report("read_request", rsp.read_request, e.read_request);
        if (rsp.writeback_request != e.writeback_request)
          report("writeback_request", rsp.writeback_request, e.writeback_request);
        if (rsp.writeback_page != e.writeback_page)
          report("writeback_page", rsp.writeback_page, e.writeback_page);
      end
      checked++;
    end
  end

  function automatic logic [bpfm_pkg::PAGE_W-1:0] pick_page();
    int k;
    k = $urandom_range(99);
    if (k < 40) return hot[$urandom_range(7)];
    if (k < 85) return bpfm_pkg::PAGE_W'($urandom_range(95));
    return $urandom;
  endfunction

  task automatic test_directed;
    send_req(bpfm_pkg::REQ_FLUSH, 32'd5, 1'b0);
    send_req(bpfm_pkg::REQ_UNPIN, 32'd5, 1'b0);
    send_req(bpfm_pkg::REQ_DELETE, 32'd5, 1'b0);
    send_req(bpfm_pkg::REQ_FETCH, 32'd0, 1'b0);
    send_req(bpfm_pkg::REQ_FETCH, 32'hFFFF_FFFF, 1'b0);
    send_req(bpfm_pkg::REQ_NEW, 32'hA5A5_5A5A, 1'b0);
    send_req(bpfm_pkg::REQ_FETCH, 32'd0, 1'b0);
    send_req(bpfm_pkg::REQ_NEW, 32'd0, 1'b0);
    send_req(bpfm_pkg::REQ_DELETE, 32'd0, 1'b0);
    for (int i = 0; i < 3; i++) send_req(bpfm_pkg::REQ_UNPIN, 32'd0, i[0]);
    send_req(bpfm_pkg::REQ_UNPIN, 32'd0, 1'b1);
    send_req(bpfm_pkg::REQ_FLUSH, 32'd0, 1'b0);
    send_req(bpfm_pkg::REQ_FLUSH, 32'd0, 1'b0);
    send_req(bpfm_pkg::REQ_UNPIN, 32'hFFFF_FFFF, 1'b1);
    send_req(bpfm_pkg::REQ_DELETE, 32'hFFFF_FFFF, 1'b0);
    send_req(bpfm_pkg::REQ_DELETE, 32'd0, 1'b0);
    send_req(3'd5, 32'd7, 1'b1);
    send_req(3'd7, 32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  // fill every frame pinned, then misses find no frame, then evict through lru
  task automatic test_eviction;
    for (int i = 0; i < bpfm_pkg::NUM_FRAMES; i++)
      send_req(bpfm_pkg::REQ_NEW, 32'h1000 + i, 1'b0);
    send_req(bpfm_pkg::REQ_FETCH, 32'h9999, 1'b0);
    send_req(bpfm_pkg::REQ_NEW, 32'h9998, 1'b0);
    for (int i = 0; i < bpfm_pkg::NUM_FRAMES; i += 2)
      send_req(bpfm_pkg::REQ_UNPIN, 32'h1000 + i, i[1]);
    for (int i = 0; i < 8; i++) send_req(bpfm_pkg::REQ_FETCH, 32'h2000 + i, 1'b0);
    for (int i = 0; i < bpfm_pkg::NUM_FRAMES; i++)
      send_req(bpfm_pkg::REQ_UNPIN, 32'h1000 + i, 1'b0);
    for (int i = 0; i < 8; i++) send_req(bpfm_pkg::REQ_UNPIN, 32'h2000 + i, 1'b1);
    for (int i = 0; i < bpfm_pkg::NUM_FRAMES; i++)
      send_req(bpfm_pkg::REQ_DELETE, 32'h1000 + i, 1'b0);
    drain();
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    int k;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 30) send_req(bpfm_pkg::REQ_FETCH, pick_page(), 1'b0);
      else if (k < 42) send_req(bpfm_pkg::REQ_NEW, pick_page(), 1'b0);
      else if (k < 72) send_req(bpfm_pkg::REQ_UNPIN, pick_page(), 1'($urandom));
      else if (k < 84) send_req(bpfm_pkg::REQ_FLUSH, pick_page(), 1'($urandom));
      else if (k < 97) send_req(bpfm_pkg::REQ_DELETE, pick_page(), 1'($urandom));
      else send_req(3'($urandom_range(7, 5)), $urandom, 1'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_req(bpfm_pkg::REQ_FLUSH, pick_page(), 1'b0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < bpfm_pkg::NUM_FRAMES; i++) begin
      pg_num[i] = '0;
      pg_valid[i] = 1'b0;
      pg_dirty[i] = 1'b0;
      pg_pins[i] = 0;
      free_q = {free_q, i};
    end
    for (int i = 0; i < 8; i++) hot[i] = $urandom;
    hot[0] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_eviction();
    test_random(400, 0, 0);
    test_random(400, 48, 0);
    test_random(400, 0, 48);
    test_random(400, 18, 18);
    test_backpressure();
    $display("covered all request kinds, pool exhaustion, lru eviction and write-backs");
    $display("results checked: %0d under four idle patterns and a long output hold-off", checked);
    if (errors == 0 && pending.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
